// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define Q2E_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("q2e assertion failed");
`define Q2E_ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("q2e assertion failed");
`else
`define Q2E_ASSERT(name, prop)
`define Q2E_ASSERT_CLK(name, clk, rst_n, prop)
`endif
`endif

// File: rtl/core/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

  localparam int Q15_W      = 16;
  localparam int PROD_W     = 32;
  localparam int CORDIC_W   = 38;
  localparam int ANG_W      = 36;
  localparam int SQ_W       = 62;
  localparam int SQRT_STEPS = 31;
  localparam int OUT_W      = 16;

  localparam logic [23:0] THR_RESET = 24'd8388600;
  localparam logic        REG_POLE_THR = 1'b0;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [OUT_W-1:0] HALF_PI_Q12 = 16'sd6434;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

  localparam logic [30:0] ATAN_TAB [32] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
  };

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANG_W-1:0]    ang;
    logic                       zero;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    pole_e pole;
    logic  neg;
  } tag_t;

  // Round half up from Q8.30 to Q4.12, then saturate.
  function automatic logic signed [OUT_W-1:0] round_q12(
      input logic signed [ANG_W+1:0] a);
    logic signed [ANG_W+1:0] r;
    r = (a + 38'sd131072) >>> 18;
    if (r > 38'sd32767) begin
      return 16'sh7fff;
    end else if (r < -38'sd32768) begin
      return 16'sh8000;
    end else begin
      return r[OUT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/q2e_cordic_cell.sv
`default_nettype none
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic    clk_i,
  input  wire logic    en_i,
  input  wire cordic_t cell_i,
  output cordic_t      cell_o
);

  localparam logic signed [ANG_W-1:0] ATAN_K =
    signed'({{(ANG_W-31){1'b0}}, ATAN_TAB[STAGE]});

  cordic_t cell_d, cell_q;
  logic signed [CORDIC_W-1:0] xs, ys;

  always_comb begin
    xs = cell_i.x >>> STAGE;
    ys = cell_i.y >>> STAGE;
    cell_d = cell_i;
    if (cell_i.y > 0) begin
      cell_d.x   = cell_i.x + ys;
      cell_d.y   = cell_i.y - xs;
      cell_d.ang = cell_i.ang + ATAN_K;
    end else begin
      cell_d.x   = cell_i.x - ys;
      cell_d.y   = cell_i.y + xs;
      cell_d.ang = cell_i.ang - ATAN_K;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// File: rtl/core/q2e_cordic.sv
`default_nettype none
module q2e_cordic
  import q2e_pkg::*;
#(
  parameter int STAGES = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic signed [CORDIC_W-1:0] x_i,
  input  wire logic signed [CORDIC_W-1:0] y_i,
  output logic signed [ANG_W-1:0]         ang_o
);

  cordic_t pre_d, pre_q;
  cordic_t chain [STAGES+1];

  // Fold the left half plane onto the right one.
  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.x    = x_i;
    pre_d.y    = y_i;
    pre_d.ang  = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        pre_d.x   = y_i;
        pre_d.y   = -x_i;
        pre_d.ang = HALF_PI_Q30;
      end else begin
        pre_d.x   = -y_i;
        pre_d.y   = x_i;
        pre_d.ang = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_q <= pre_d;
    end
  end

  assign chain[0] = pre_q;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    q2e_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  assign ang_o = chain[STAGES].zero ? '0 : chain[STAGES].ang;

endmodule
`default_nettype wire

// File: rtl/core/q2e_sqrt_cell.sv
`default_nettype none
module q2e_sqrt_cell
  import q2e_pkg::*;
#(
  parameter int J = 0
) (
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  wire sqrt_t cell_i,
  output sqrt_t      cell_o
);

  localparam logic [SQ_W-1:0] BIT_K = SQ_W'(1) << (2 * J);

  sqrt_t cell_d, cell_q;
  logic [SQ_W:0] trial;

  always_comb begin
    trial = {1'b0, cell_i.res} + {1'b0, BIT_K};
    if ({1'b0, cell_i.rem} >= trial) begin
      cell_d.rem = cell_i.rem - trial[SQ_W-1:0];
      cell_d.res = (cell_i.res >> 1) + BIT_K;
    end else begin
      cell_d.rem = cell_i.rem;
      cell_d.res = cell_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

// File: rtl/core/q2e_isqrt.sv
`default_nettype none
module q2e_isqrt
  import q2e_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [SQ_W-1:0] rad_i,
  output logic [SQ_W-1:0]      root_o
);

  sqrt_t chain [SQRT_STEPS+1];

  assign chain[0].rem = rad_i;
  assign chain[0].res = '0;

  // One result bit per cell, most significant first.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
    q2e_sqrt_cell #(.J(SQRT_STEPS - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  assign root_o = chain[SQRT_STEPS].res;

endmodule
`default_nettype wire

// File: rtl/core/quaternion_to_euler_core.sv
// Throughput: one item per cycle; the whole pipeline holds while an output
// item waits for m_axis_tready.
// The square root is computed one result bit per cell.
// Reset clears all valid bits and loads pole_threshold with 8388600.
`default_nettype none
`include "assert_macros.svh"
module quaternion_to_euler_core
  import q2e_pkg::*;
#(
  parameter int COMP_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // comp_x, comp_y, comp_z, comp_w, zero fill
  input  wire logic [((4*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // roll_angle, pitch_angle, yaw_angle
  output logic [47:0]              m_axis_tdata,
  // pole_case
  output logic [1:0]               m_axis_tuser,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int LAT     = 39 + CORDIC_STAGES;
  localparam int M2_DLY  = 33;
  localparam int ANG_DLY = 32;
  localparam int TAG_DLY = 33 + CORDIC_STAGES;

  logic en;
  logic [LAT-1:0] vld_q;
  logic [23:0] thr_q;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POLE_THR) ? {8'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_POLE_THR)) begin
      thr_q <= pwdata[23:0];
    end
  end

  // pipeline control: advance all stages together
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // stage 1: bring components to Q1.15
  logic signed [COMP_WIDTH-1:0] raw [4];
  logic signed [Q15_W-1:0] q15 [4];
  logic signed [Q15_W-1:0] x1_q, y1_q, z1_q, w1_q;

  for (genvar c = 0; c < 4; c++) begin : g_comp
    assign raw[c] = s_axis_tdata[c*COMP_WIDTH +: COMP_WIDTH];
    if (COMP_WIDTH >= Q15_W) begin : g_down
      assign q15[c] = Q15_W'(raw[c] >>> (COMP_WIDTH - Q15_W));
    end else begin : g_up
      assign q15[c] = Q15_W'(raw[c]) <<< (Q15_W - COMP_WIDTH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= q15[0];
      y1_q <= q15[1];
      z1_q <= q15[2];
      w1_q <= q15[3];
    end
  end

  // stage 2: products
  logic signed [PROD_W-1:0] p_xx_q, p_yy_q, p_zz_q, p_ww_q, p_xz_q;
  logic signed [PROD_W-1:0] p_wy_q, p_wz_q, p_xy_q, p_wx_q, p_yz_q;
  logic signed [Q15_W-1:0] x2_q, w2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_xx_q <= x1_q * x1_q;
      p_yy_q <= y1_q * y1_q;
      p_zz_q <= z1_q * z1_q;
      p_ww_q <= w1_q * w1_q;
      p_xz_q <= x1_q * z1_q;
      p_wy_q <= w1_q * y1_q;
      p_wz_q <= w1_q * z1_q;
      p_xy_q <= x1_q * y1_q;
      p_wx_q <= w1_q * x1_q;
      p_yz_q <= y1_q * z1_q;
      x2_q   <= x1_q;
      w2_q   <= w1_q;
    end
  end

  // stage 3: sums
  logic [32:0] norm_q;
  logic signed [32:0] test_q, yd3_q, rd3_q;
  logic signed [33:0] yn3_q, rn3_q;
  logic signed [Q15_W-1:0] x3_q, w3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      norm_q <= 33'(p_xx_q) + 33'(p_yy_q) + 33'(p_zz_q) + 33'(p_ww_q);
      test_q <= 33'(p_xz_q) + 33'(p_wy_q);
      yn3_q  <= (34'(p_wz_q) - 34'(p_xy_q)) <<< 1;
      yd3_q  <= 33'(p_ww_q) + 33'(p_xx_q) - 33'(p_yy_q) - 33'(p_zz_q);
      rn3_q  <= (34'(p_wx_q) - 34'(p_yz_q)) <<< 1;
      rd3_q  <= 33'(p_ww_q) - 33'(p_xx_q) - 33'(p_yy_q) + 33'(p_zz_q);
      x3_q   <= x2_q;
      w3_q   <= w2_q;
    end
  end

  // stage 4: threshold product, pitch operands
  logic [56:0] rhs_q;
  logic signed [32:0] test4_q, yd4_q, rd4_q;
  logic signed [33:0] yn4_q, rn4_q;
  logic signed [Q15_W-1:0] x4_q, w4_q;
  logic [30:0] m2_q, n2_q;
  logic [32:0] t_abs;

  assign t_abs = test_q[32] ? 33'(-test_q) : 33'(test_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rhs_q   <= 57'(thr_q) * 57'(norm_q);
      test4_q <= test_q;
      m2_q    <= t_abs[31:1];
      n2_q    <= norm_q[32:2];
      yn4_q   <= yn3_q;
      yd4_q   <= yd3_q;
      rn4_q   <= rn3_q;
      rd4_q   <= rd3_q;
      x4_q    <= x3_q;
      w4_q    <= w3_q;
    end
  end

  // stage 5: pole decision, squares for the radicand, CORDIC operands
  logic signed [58:0] lhs_e, rhs_e;
  logic north, south;
  tag_t tag_d, tag5_q;
  logic [SQ_W-1:0] a_q, b_q;
  logic signed [CORDIC_W-1:0] yaw_x_q, yaw_y_q, roll_x_q, roll_y_q;

  assign lhs_e = {{2{test4_q[32]}}, test4_q, 24'd0};
  assign rhs_e = signed'({2'b00, rhs_q});
  assign north = lhs_e > rhs_e;
  assign south = lhs_e < -rhs_e;

  always_comb begin
    tag_d.neg = test4_q[32];
    if (north) begin
      tag_d.pole = POLE_NORTH;
    end else if (south) begin
      tag_d.pole = POLE_SOUTH;
    end else begin
      tag_d.pole = POLE_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag5_q <= tag_d;
      a_q    <= SQ_W'(n2_q) * SQ_W'(n2_q);
      b_q    <= SQ_W'(m2_q) * SQ_W'(m2_q);
      if (north || south) begin
        yaw_y_q <= CORDIC_W'(x4_q) <<< 16;
        yaw_x_q <= CORDIC_W'(w4_q) <<< 16;
      end else begin
        yaw_y_q <= CORDIC_W'(yn4_q);
        yaw_x_q <= CORDIC_W'(yd4_q);
      end
      roll_y_q <= CORDIC_W'(rn4_q);
      roll_x_q <= CORDIC_W'(rd4_q);
    end
  end

  // stage 6: radicand, clamped at zero
  logic [SQ_W-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= (a_q > b_q) ? a_q - b_q : '0;
    end
  end

  logic [SQ_W-1:0] root;
  q2e_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  // hold m2 beside the square root
  logic [30:0] m2_dl_q [M2_DLY];
  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_dl_q[0] <= m2_q;
      for (int k = 1; k < M2_DLY; k++) begin
        m2_dl_q[k] <= m2_dl_q[k-1];
      end
    end
  end

  logic signed [ANG_W-1:0] yaw_ang, roll_ang, pitch_ang;

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (yaw_x_q),
    .y_i   (yaw_y_q),
    .ang_o (yaw_ang)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (roll_x_q),
    .y_i   (roll_y_q),
    .ang_o (roll_ang)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (signed'(CORDIC_W'(root))),
    .y_i   (signed'(CORDIC_W'(m2_dl_q[M2_DLY-1]))),
    .ang_o (pitch_ang)
  );

  // align yaw and roll with pitch
  logic signed [ANG_W-1:0] yaw_dl_q [ANG_DLY];
  logic signed [ANG_W-1:0] roll_dl_q [ANG_DLY];
  tag_t tag_dl_q [TAG_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_dl_q[0]  <= yaw_ang;
      roll_dl_q[0] <= roll_ang;
      for (int k = 1; k < ANG_DLY; k++) begin
        yaw_dl_q[k]  <= yaw_dl_q[k-1];
        roll_dl_q[k] <= roll_dl_q[k-1];
      end
      tag_dl_q[0] <= tag5_q;
      for (int k = 1; k < TAG_DLY; k++) begin
        tag_dl_q[k] <= tag_dl_q[k-1];
      end
    end
  end

  // output stage
  tag_t tag_o;
  logic signed [ANG_W+1:0] yaw_full, pitch_full, roll_full, yaw_ext, pitch_ext;
  logic signed [OUT_W-1:0] roll_o, pitch_o, yaw_o;

  assign tag_o = tag_dl_q[TAG_DLY-1];

  always_comb begin
    yaw_ext   = (ANG_W+2)'(yaw_dl_q[ANG_DLY-1]);
    pitch_ext = (ANG_W+2)'(pitch_ang);
    roll_full = '0;
    case (tag_o.pole)
      POLE_NORTH: begin
        yaw_full   = yaw_ext <<< 1;
        pitch_full = (ANG_W+2)'(HALF_PI_Q30);
      end
      POLE_SOUTH: begin
        yaw_full   = -(yaw_ext <<< 1);
        pitch_full = -(ANG_W+2)'(HALF_PI_Q30);
      end
      default: begin
        yaw_full   = yaw_ext;
        pitch_full = tag_o.neg ? -pitch_ext : pitch_ext;
        roll_full  = (ANG_W+2)'(roll_dl_q[ANG_DLY-1]);
      end
    endcase
    roll_o  = round_q12(roll_full);
    pitch_o = round_q12(pitch_full);
    yaw_o   = round_q12(yaw_full);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {yaw_o, pitch_o, roll_o};
      m_axis_tuser <= tag_o.pole;
    end
  end

  `Q2E_ASSERT(a_north_pitch, m_axis_tvalid && (m_axis_tuser == POLE_NORTH) |-> m_axis_tdata[31:16] == HALF_PI_Q12)
  `Q2E_ASSERT(a_pole_roll, m_axis_tvalid && (m_axis_tuser != POLE_NONE) |-> m_axis_tdata[15:0] == 16'd0)
  `Q2E_ASSERT(a_stall_hold, !en |=> $stable(vld_q))

endmodule
`default_nettype wire
